// ----- src/pidw_pkg.sv -----
// ----------------------------------------------------------------------------
// pidw_pkg
// Shared widths, register indexes and types for the PID drive block.
// ----------------------------------------------------------------------------
package pidw_pkg;

  localparam int DATA_WIDTH     = 16;
  localparam int GAIN_FRAC_BITS = 8;

  // config registers are fixed at 16 bits
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam int ERR_W    = DATA_WIDTH + 1;
  localparam int DIFF_W   = DATA_WIDTH + 2;
  // integral is bounded by a 16 bit limit plus one in-window error
  localparam int INTEG_W  = CFG_W + 2;
  localparam int IADD_W   = ((ERR_W > INTEG_W) ? ERR_W : INTEG_W) + 1;
  localparam int PROD_P_W = ERR_W + CFG_W;
  localparam int PROD_I_W = INTEG_W + CFG_W;
  localparam int PROD_D_W = DIFF_W + CFG_W;
  localparam int SUM_W    = ((PROD_D_W > PROD_I_W) ? PROD_D_W : PROD_I_W) + 2;
  localparam int DRIVE_W  = DATA_WIDTH + 1;

  localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DRIVE_W + 7) / 8) * 8;

  // added to negative sums so the shift truncates toward zero
  localparam logic [SUM_W-1:0] ROUND_BIAS =
    SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_WINDOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIVE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_P_ONLY       = 3'd6;

  typedef struct packed {
    logic signed [CFG_W-1:0] gain_p;
    logic signed [CFG_W-1:0] gain_i;
    logic signed [CFG_W-1:0] gain_d;
    logic [CFG_W-1:0]        integ_window;
    logic [CFG_W-1:0]        integ_limit;
    logic [CFG_W-1:0]        max_drive;
    logic                    p_only;
  } pidw_cfg_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] setpoint;
    logic signed [DATA_WIDTH-1:0] measured;
    logic                         start_req;
  } pidw_item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      settled;
  } pidw_res_t;

endpackage

// ----- src/pidw_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pidw_cfg_regs
// Configuration register file, one write request per cycle.
// ----------------------------------------------------------------------------
module pidw_cfg_regs
  import pidw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output pidw_cfg_t            cfg
);

  pidw_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_GAIN_P:       cfg_nxt.gain_p       = $signed(wr_data);
        REG_GAIN_I:       cfg_nxt.gain_i       = $signed(wr_data);
        REG_GAIN_D:       cfg_nxt.gain_d       = $signed(wr_data);
        REG_INTEG_WINDOW: cfg_nxt.integ_window = wr_data;
        REG_INTEG_LIMIT:  cfg_nxt.integ_limit  = wr_data;
        REG_MAX_DRIVE:    cfg_nxt.max_drive    = wr_data;
        REG_P_ONLY:       cfg_nxt.p_only       = wr_data[0];
        default:          cfg_nxt = cfg_r;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p       <= CFG_W'(256);
      cfg_r.gain_i       <= '0;
      cfg_r.gain_d       <= '0;
      cfg_r.integ_window <= CFG_W'(10);
      cfg_r.integ_limit  <= CFG_W'(100);
      cfg_r.max_drive    <= CFG_W'(1000);
      cfg_r.p_only       <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/pidw_step.sv -----
// ----------------------------------------------------------------------------
// pidw_step
// One control step: error, windowed integral, derivative, gain products,
// scale and clamp. Holds last_error and integral_sum.
// ----------------------------------------------------------------------------
module pidw_step
  import pidw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,     // item leaves the input stage this cycle
  input  pidw_item_t item,
  input  pidw_cfg_t  cfg,
  output pidw_res_t  res
);

  logic signed [ERR_W-1:0]    last_err_r, last_err_nxt;
  logic signed [INTEG_W-1:0]  integ_r, integ_nxt;

  logic signed [ERR_W-1:0]    err, prev;
  logic signed [INTEG_W-1:0]  integ_base, integ_new;
  logic signed [IADD_W-1:0]   err_x, win_x, lim_x, integ_sum, integ_pre, integ_clamp;
  logic                       in_win;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [SUM_W-1:0]    sum, scaled, md_x, drive_c;
  logic [SUM_W-1:0]           sum_b;

  always_comb begin
    err = ERR_W'(item.setpoint) - ERR_W'(item.measured);
    // start request wipes state before the step
    prev       = item.start_req ? '0 : last_err_r;
    integ_base = item.start_req ? '0 : integ_r;

    err_x  = IADD_W'(err);
    win_x  = $signed(IADD_W'(cfg.integ_window));
    lim_x  = $signed(IADD_W'(cfg.integ_limit));
    in_win = (err != '0) && (err_x < win_x) && (err_x > -win_x);

    integ_sum = IADD_W'(integ_base) + err_x;
    integ_pre = in_win ? integ_sum : '0;
    if (integ_pre > lim_x)
      integ_clamp = lim_x;
    else if (integ_pre < -lim_x)
      integ_clamp = -lim_x;
    else
      integ_clamp = integ_pre;
    integ_new = INTEG_W'(integ_clamp);

    diff   = DIFF_W'(err) - DIFF_W'(prev);
    prod_p = PROD_P_W'(err) * PROD_P_W'($signed(cfg.gain_p));
    prod_i = PROD_I_W'(integ_new) * PROD_I_W'($signed(cfg.gain_i));
    prod_d = (err == '0) ? '0 : PROD_D_W'(diff) * PROD_D_W'($signed(cfg.gain_d));

    if (cfg.p_only)
      sum = SUM_W'(prod_p);
    else
      sum = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);

    sum_b  = sum + (sum[SUM_W-1] ? ROUND_BIAS : '0);
    scaled = $signed(sum_b) >>> GAIN_FRAC_BITS;

    md_x = $signed(SUM_W'(cfg.max_drive));
    if (scaled > md_x)
      drive_c = md_x;
    else if (scaled < -md_x)
      drive_c = -md_x;
    else
      drive_c = scaled;

    res.drive   = DRIVE_W'(drive_c);
    res.settled = (err == '0) && (prev == '0);

    // P-only keeps state, except that a start request still clears it
    if (cfg.p_only) begin
      last_err_nxt = prev;
      integ_nxt    = integ_base;
    end else begin
      last_err_nxt = err;
      integ_nxt    = integ_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      integ_r    <= '0;
    end else if (adv) begin
      last_err_r <= last_err_nxt;
      integ_r    <= integ_nxt;
    end
  end

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item.start_req && cfg.p_only |=> (last_err_r == '0) && (integ_r == '0))
    else $error("start request did not clear state");

  a_ponly_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !item.start_req && cfg.p_only |=> $stable(last_err_r) && $stable(integ_r))
    else $error("P-only step changed state");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(last_err_r) && $stable(integ_r))
    else $error("state moved without a step");

endmodule

// ----- src/pid_drive_with_windup_limits.sv -----
// ----------------------------------------------------------------------------
// pid_drive_with_windup_limits
// PID drive step with windowed, clamped integral and saturated output.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata: setpoint, measured; tuser: start
//  out_    | out | out_tvalid/tready  | tdata: drive (17b signed); tuser: settled
//  cfg_    | in  | cfg_valid/ready    | cfg_index (3b), cfg_data (16b)
//
//  One request per cycle sustained while out_tready stays high; a result passes
//  the input register, one combinational pass with the three gain multiplies,
//  sum and clamp, then the output register.
//  Control state feeds back within that pass, so requests never wait on each other.
//  rst_n (sync, active low) restores register defaults and zeroes state.
//  A stalled output with a full input register drops in_tready; cfg_ready is 1.
//
module pid_drive_with_windup_limits
  import pidw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] setpoint, [31:16] measured
  input  logic                   in_tuser,   // [0] start_req
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [16:0] drive, rest zero
  output logic                   out_tuser,  // [0] settled
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  pidw_cfg_t  cfg;
  pidw_item_t in_item_r, in_item_nxt;
  pidw_res_t  step_res;
  pidw_res_t  out_res_r, out_res_nxt;
  logic       in_vld_r, in_vld_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic       adv, in_acc;

  assign cfg_ready = 1'b1;

  pidw_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // input stage moves on when the output register is free or draining
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    in_item_nxt = in_item_r;
    if (in_acc) begin
      in_item_nxt.setpoint  = $signed(in_tdata[DATA_WIDTH-1:0]);
      in_item_nxt.measured  = $signed(in_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
      in_item_nxt.start_req = in_tuser;
    end
    if (in_acc)
      in_vld_nxt = 1'b1;
    else if (adv)
      in_vld_nxt = 1'b0;
    else
      in_vld_nxt = in_vld_r;

    out_res_nxt = adv ? step_res : out_res_r;
    if (adv)
      out_vld_nxt = 1'b1;
    else if (out_tready)
      out_vld_nxt = 1'b0;
    else
      out_vld_nxt = out_vld_r;
  end

  pidw_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (step_res)
  );

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'($unsigned(out_res_r.drive));
  assign out_tuser  = out_res_r.settled;

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && !out_tready |-> !in_tready)
    else $error("input taken while both stages are full");

  a_step_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("step result not registered");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_vld_r)
    else $error("accepted request lost at input stage");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PID drive block: a directed table of requests,
// then randomized control runs under changing gains and limits. Results are checked
// against a cycle-free bench model of the control law or a pinned expectation.
// ----------------------------------------------------------------------------
module tb;
  import pidw_pkg::*;

  localparam int  HOLD_CYCLES  = 300;      // long output back-pressure
  localparam int  DRAIN_CYCLES = 4;        // pipeline is two stages deep
  localparam int  PHASES       = 8;
  localparam int  PHASE_ITEMS  = 250;
  localparam time TIMEOUT_NS   = 2_000_000;

  // index 7 is not decoded by the block; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [15:0] setpoint, [31:16] measured
  logic                   in_tuser   = 1'b0; // [0] start_req
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [16:0] drive, upper bits zero
  logic                   out_tuser;         // [0] settled
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_W-1:0]       cfg_data   = '0;

  always #1 clk = ~clk;

  pid_drive_with_windup_limits u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Control-law model: bench copy of the registers and loop state.
  // Registers start at their reset defaults; reset happens once.
  // --------------------------------------------------------------------------
  logic signed [CFG_W-1:0] kp = 16'sd256;
  logic signed [CFG_W-1:0] ki = 16'sd0;
  logic signed [CFG_W-1:0] kd = 16'sd0;
  logic [CFG_W-1:0]        win  = 16'd10;
  logic [CFG_W-1:0]        ilim = 16'd100;
  logic [CFG_W-1:0]        dmax = 16'd1000;
  logic                    prop_only = 1'b0;

  logic signed [ERR_W-1:0]   prev_err  = '0;
  logic signed [INTEG_W-1:0] integ_acc = '0;

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
    case (idx)
      REG_GAIN_P:       kp = val;
      REG_GAIN_I:       ki = val;
      REG_GAIN_D:       kd = val;
      REG_INTEG_WINDOW: win = val;
      REG_INTEG_LIMIT:  ilim = val;
      REG_MAX_DRIVE:    dmax = val;
      REG_P_ONLY:       prop_only = val[0];
      default: ;  // undecoded index, no effect
    endcase
  endfunction

  // One control step. Updates loop state unless proportional-only is set, when only a start clears it.
  function automatic pidw_res_t drive_step(input pidw_item_t it);
    longint    e, prev, acc, dterm, total, q, lim;
    pidw_res_t r;
    e = longint'(it.setpoint) - longint'(it.measured);
    // start clears state first, even in proportional-only mode
    if (it.start_req) begin
      prev_err  = '0;
      integ_acc = '0;
    end
    prev = longint'(prev_err);
    if (prop_only) begin
      total = e * longint'(kp);
    end else begin
      acc = longint'(integ_acc);
      // integrate only strictly inside the window and on nonzero error
      if (e != 0 && e < longint'(win) && e > -longint'(win))
        acc = acc + e;
      else
        acc = 0;
      lim = longint'(ilim);
      if (acc > lim) acc = lim;
      else if (acc < -lim) acc = -lim;
      dterm = (e == 0) ? 0 : (e - prev) * longint'(kd);
      total = e * longint'(kp) + acc * longint'(ki) + dterm;
      integ_acc = acc[INTEG_W-1:0];
      prev_err  = e[ERR_W-1:0];
    end
    q   = total / (longint'(1) << GAIN_FRAC_BITS);  // truncates toward zero
    lim = longint'(dmax);
    if (q > lim) q = lim;
    else if (q < -lim) q = -lim;
    r.drive   = q[DRIVE_W-1:0];
    r.settled = (e == 0 && prev == 0);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard
  // --------------------------------------------------------------------------
  typedef struct {
    logic      chk;   // typed-in expectation overrides the model
    pidw_res_t res;
  } pinned_t;

  pidw_res_t pending[$];   // expected drives, oldest first
  pinned_t   pinned_q[$];  // one per offered request, in order

  int errors    = 0;
  int n_in      = 0;
  int n_out     = 0;
  int n_cfg     = 0;
  int n_starts  = 0;
  int n_pmode   = 0;
  int n_settled = 0;
  int n_holds   = 0;

  always @(posedge clk) begin : scoreboard
    pidw_item_t        it;
    pidw_res_t         r;
    pidw_res_t         exp_r;
    pinned_t           pin;
    logic signed [DRIVE_W-1:0] got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        n_cfg++;
      end
      if (in_tvalid && in_tready) begin
        it.setpoint  = in_tdata[DATA_WIDTH-1:0];
        it.measured  = in_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
        it.start_req = in_tuser;
        if (prop_only) n_pmode++;
        if (in_tuser) n_starts++;
        r = drive_step(it);
        if (pinned_q.size() != 0) begin
          pin = pinned_q.pop_front();
          if (pin.chk) r = pin.res;
        end
        pending.push_back(r);
        n_in++;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[DRIVE_W-1:0];
        n_out++;
        if (out_tuser) n_settled++;
        if (pending.size() == 0) begin
          $display("%0t ns: result with nothing expected, drive %0d settled %0b",
                   $time, got, out_tuser);
          errors++;
        end else begin
          exp_r = pending.pop_front();
          if (got !== exp_r.drive) begin
            $display("%0t ns: drive mismatch, expected %0d, got %0d",
                     $time, exp_r.drive, got);
            errors++;
          end
          if (out_tuser !== exp_r.settled) begin
            $display("%0t ns: settled mismatch, expected %0b, got %0b",
                     $time, exp_r.settled, out_tuser);
            errors++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: random gaps on both sides, quiet stretches, one long hold
  // --------------------------------------------------------------------------
  bit steady   = 1'b0;  // no idling on either side during this phase
  bit hold_req = 1'b0;  // ask the receiver for one long back-pressure stretch

  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  int hold_left  = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      // sender keeps offering; the block must fill up and stall its input
      hold_req   = 1'b0;
      hold_left  = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
      n_holds++;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      stall_left = gap_len();
    end
  end

  // --------------------------------------------------------------------------
  // Request and register drivers
  // --------------------------------------------------------------------------

  // Offers one request and returns at the edge that took it; valid stays high
  // if no gap follows, so back-to-back requests keep the channel busy.
  task automatic push_req(input logic [DATA_WIDTH-1:0] sp,
                          input logic [DATA_WIDTH-1:0] pv,
                          input logic st, input logic chk,
                          input logic [DRIVE_W-1:0] drv, input logic stl);
    pinned_t pin;
    int      gap;
    pin.chk         = chk;
    pin.res.drive   = drv;
    pin.res.settled = stl;
    pinned_q.push_back(pin);
    in_tvalid <= 1'b1;
    in_tdata  <= {pv, sp};
    in_tuser  <= st;
    do @(posedge clk); while (!in_tready);
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Stop offering and wait for every outstanding drive to come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_gain();
    case ($urandom_range(0, 7)) inside
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3, 4:    return 16'(int'($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  typedef struct {
    bit                         is_reg;
    logic [DATA_WIDTH-1:0]      sp;
    logic [DATA_WIDTH-1:0]      pv;
    logic                       st;
    logic                       chk;
    logic [DRIVE_W-1:0]         drv;
    logic                       stl;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_W-1:0]           val;
  } step_row_t;

  step_row_t plan[$];

  function automatic step_row_t item_row(input int sp, input int pv, input bit st);
    step_row_t r;
    r.is_reg = 1'b0;
    r.sp     = sp[DATA_WIDTH-1:0];
    r.pv     = pv[DATA_WIDTH-1:0];
    r.st     = st;
    r.chk    = 1'b0;
    r.drv    = '0;
    r.stl    = 1'b0;
    r.idx    = '0;
    r.val    = '0;
    return r;
  endfunction

  function automatic step_row_t pinned_row(input int sp, input int pv, input bit st,
                                           input int drv, input bit stl);
    step_row_t r;
    r     = item_row(sp, pv, st);
    r.chk = 1'b1;
    r.drv = drv[DRIVE_W-1:0];
    r.stl = stl;
    return r;
  endfunction

  function automatic step_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] val);
    step_row_t r;
    r        = item_row(0, 0, 1'b0);
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    bit                    in_reg;
    int                    base, delta, kind;
    logic [DATA_WIDTH-1:0] sp, pv;

    // defaults: kp 1.0, no I or D, window 10, limit 100, max 1000
    plan.push_back(pinned_row(0, 0, 0, 0, 1));                // zero error, settled
    plan.push_back(pinned_row(100, 0, 0, 100, 0));            // unity P gain
    plan.push_back(pinned_row(32767, -32768, 0, 1000, 0));    // largest error, clamped
    plan.push_back(pinned_row(-32768, 32767, 0, -1000, 0));   // most negative error
    plan.push_back(pinned_row(5, 5, 0, 0, 0));                // previous error nonzero
    plan.push_back(pinned_row(5, 5, 0, 0, 1));                // two zero errors
    plan.push_back(pinned_row(1, 0, 1, 1, 0));                // start request
    // integral and derivative active, tight integral limit
    plan.push_back(reg_row(REG_GAIN_I, 16'sd256));
    plan.push_back(reg_row(REG_GAIN_D, -16'sd512));
    plan.push_back(reg_row(REG_INTEG_LIMIT, 16'd5));
    plan.push_back(item_row(3, 0, 0));
    plan.push_back(item_row(4, 0, 0));                        // integral hits limit
    plan.push_back(item_row(0, -20, 0));                      // outside window, cleared
    plan.push_back(item_row(0, 0, 0));                        // no D term on zero error
    plan.push_back(item_row(-9, 0, 0));                       // just inside window
    plan.push_back(item_row(-10, 0, 0));                      // on the window edge
    // proportional-only: state left alone, start still clears it
    plan.push_back(reg_row(REG_P_ONLY, 16'd1));
    plan.push_back(item_row(7, 0, 0));
    plan.push_back(item_row(0, 0, 1));
    plan.push_back(reg_row(REG_P_ONLY, 16'd0));
    // zero window never integrates
    plan.push_back(reg_row(REG_INTEG_WINDOW, 16'd0));
    plan.push_back(item_row(1, 0, 0));
    // zero limits force zero drive
    plan.push_back(reg_row(REG_INTEG_LIMIT, 16'd0));
    plan.push_back(reg_row(REG_MAX_DRIVE, 16'd0));
    plan.push_back(pinned_row(-32768, 32767, 0, 0, 0));
    // undecoded index, then every gain and limit at its extreme
    plan.push_back(reg_row(REG_SPARE, 16'hFFFF));
    plan.push_back(reg_row(REG_GAIN_P, 16'h8000));
    plan.push_back(reg_row(REG_GAIN_I, 16'h7FFF));
    plan.push_back(reg_row(REG_GAIN_D, 16'h7FFF));
    plan.push_back(reg_row(REG_INTEG_WINDOW, 16'hFFFF));
    plan.push_back(reg_row(REG_INTEG_LIMIT, 16'hFFFF));
    plan.push_back(reg_row(REG_MAX_DRIVE, 16'hFFFF));
    plan.push_back(item_row(32767, -32768, 1));
    plan.push_back(item_row(-32768, 32767, 0));
    plan.push_back(item_row(32767, -32768, 0));
    plan.push_back(item_row(-1, 0, 0));
    plan.push_back(item_row(0, 0, 0));
    // only bit 0 of the mode register counts
    plan.push_back(reg_row(REG_P_ONLY, 16'hFFFE));
    plan.push_back(item_row(1, 1, 0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_reg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!in_reg) drain();
        in_reg = 1'b1;
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        if (in_reg) cfg_valid <= 1'b0;
        in_reg = 1'b0;
        push_req(plan[i].sp, plan[i].pv, plan[i].st,
                 plan[i].chk, plan[i].drv, plan[i].stl);
      end
    end

    // Randomized control runs, new register set per phase. Most requests sit
    // near the setpoint so the window, integral clamp and settling get used.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_reg(REG_GAIN_P, pick_gain());
      write_reg(REG_GAIN_I, pick_gain());
      write_reg(REG_GAIN_D, pick_gain());
      case ($urandom_range(0, 5))
        0:       write_reg(REG_INTEG_WINDOW, 16'd0);
        1:       write_reg(REG_INTEG_WINDOW, 16'hFFFF);
        2:       write_reg(REG_INTEG_WINDOW, 16'($urandom));
        default: write_reg(REG_INTEG_WINDOW, 16'($urandom_range(1, 40)));
      endcase
      case ($urandom_range(0, 5))
        0:       write_reg(REG_INTEG_LIMIT, 16'd0);
        1:       write_reg(REG_INTEG_LIMIT, 16'hFFFF);
        2:       write_reg(REG_INTEG_LIMIT, 16'($urandom));
        default: write_reg(REG_INTEG_LIMIT, 16'($urandom_range(1, 200)));
      endcase
      case ($urandom_range(0, 7)) inside
        0:       write_reg(REG_MAX_DRIVE, 16'd0);
        1, 2:    write_reg(REG_MAX_DRIVE, 16'hFFFF);
        3:       write_reg(REG_MAX_DRIVE, 16'($urandom));
        default: write_reg(REG_MAX_DRIVE, 16'($urandom_range(1, 4000)));
      endcase
      write_reg(REG_P_ONLY, {15'($urandom), ($urandom_range(0, 3) == 0)});
      if ($urandom_range(0, 1)) write_reg(REG_SPARE, 16'($urandom));
      cfg_valid <= 1'b0;

      steady = (ph == 2 || ph == 3 || ph == 6);
      if (ph == 3) hold_req = 1'b1;

      repeat (PHASE_ITEMS) begin
        kind = $urandom_range(0, 9);
        base = int'($urandom_range(0, 64000)) - 32000;
        if (kind < 6) begin
          delta = int'($urandom_range(0, 48)) - 24;
          sp = 16'(base + delta);
          pv = 16'(base);
        end else if (kind < 8) begin
          sp = 16'(base);
          pv = 16'(base);
        end else begin
          sp = 16'($urandom);
          pv = 16'($urandom);
        end
        push_req(sp, pv, ($urandom_range(0, 31) == 0), 1'b0, '0, 1'b0);
      end
    end

    drain();
    steady = 1'b0;

    $display("Covered %0d requests (%0d with start, %0d proportional-only), %0d writes.",
             n_in, n_starts, n_pmode, n_cfg);
    $display("Checked %0d drives, %0d settled, %0d long output hold(s), %0d error(s).",
             n_out, n_settled, n_holds, errors);
    if (errors == 0 && pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("%0t ns: run did not finish, %0d drive(s) outstanding", $time, pending.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
src/pidw_pkg.sv
src/pidw_cfg_regs.sv
src/pidw_step.sv
src/pid_drive_with_windup_limits.sv
test/tb.sv
